@@ rtl/lapf_pkg.sv @@
// Shared constants, widths, event codes and helpers for the LED activity pulse fader.
`default_nettype none
package lapf_pkg;

	// Timing windows in milliseconds.
	localparam int PREVIEW_LEN  = 5000;
	localparam int PULSE_STOP   = 15000;
	localparam int FADE_STOP    = 25000;
	localparam int PULSE_PERIOD = 3000;
	localparam int HALF_PERIOD  = PULSE_PERIOD / 2;
	localparam int FADE_SPAN    = (FADE_STOP > PULSE_STOP) ? (FADE_STOP - PULSE_STOP) : 1;

	// Q16 amplitude constants.
	localparam int Q_FRAC    = 16;
	localparam int Q_ONE     = 65536;
	localparam int ENV_FLOOR = 9830;
	localparam int ENV_SPAN  = Q_ONE - ENV_FLOOR;

	// Field and datapath widths.
	localparam int KIND_W    = 3;
	localparam int CH_W      = 8;
	localparam int COLOUR_W  = 3 * CH_W;
	localparam int TL_W      = 10;
	localparam int ELAPSED_W = 15;
	localparam int PHASE_W   = 12;
	localparam int UP_W      = 11;
	localparam int AMP_W     = 17;
	localparam int AMPX_W    = AMP_W + 1;
	localparam int MUL_W     = 17;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DIV_W     = 30;
	localparam int QUO_W     = 16;
	localparam int DIV_CNT_W = $clog2(QUO_W + 1);
	localparam int NUM_LANES = 3;

	// Divisors pre-aligned to the top quotient bit.
	localparam logic [DIV_W-1:0] ENV_DIV_SH  = DIV_W'(HALF_PERIOD) << (QUO_W - 1);
	localparam logic [DIV_W-1:0] FADE_DIV_SH = DIV_W'(FADE_SPAN) << (QUO_W - 1);

	// Event codes.
	localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ACTIVITY   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ACT_COLOUR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SET_COLOUR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PAUSE      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RESUME     = 3'd5;

	// Limit an amplitude to full scale.
	function automatic logic [AMP_W-1:0] clamp_amp(input logic [AMPX_W-1:0] v);
		logic [AMP_W-1:0] r;
		if (v > AMPX_W'(Q_ONE)) begin
			r = AMP_W'(Q_ONE);
		end else begin
			r = v[AMP_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/lapf_if.sv @@
// Valid/ready channel interfaces for event beats in and LED level beats out.
`default_nettype none
interface lapf_cmd_if;
	import lapf_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CH_W-1:0]   red_in;
	logic [CH_W-1:0]   green_in;
	logic [CH_W-1:0]   blue_in;
	logic              shutdown_hold;

	modport source (output valid, kind, red_in, green_in, blue_in, shutdown_hold,
		input ready);
	modport sink (input valid, kind, red_in, green_in, blue_in, shutdown_hold,
		output ready);
endinterface

interface lapf_led_if;
	import lapf_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

@@ rtl/lapf_smul.sv @@
// Bit-serial shift-and-add multiplier that stops once the multiplier bits run out.
`default_nettype none
module lapf_smul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lapf_pkg::MUL_W-1:0]  a,
	input  wire logic [lapf_pkg::MUL_W-1:0]  b,
	output logic                             busy,
	output logic [lapf_pkg::PROD_W-1:0]      product
);
	import lapf_pkg::*;

	logic                busy_q;
	logic [PROD_W-1:0]   a_q;
	logic [MUL_W-1:0]    b_q;
	logic [PROD_W-1:0]   p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= PROD_W'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= {a_q[PROD_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = p_q;

endmodule
`default_nettype wire

@@ rtl/lapf_cdiv.sv @@
// Restoring divider, one quotient bit per cycle, against a pre-aligned divisor.
`default_nettype none
module lapf_cdiv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lapf_pkg::DIV_W-1:0]  dividend,
	input  wire logic [lapf_pkg::DIV_W-1:0]  divisor_sh,
	output logic                             busy,
	output logic [lapf_pkg::QUO_W-1:0]       quotient
);
	import lapf_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ge;
	logic [DIV_W-1:0]     rem_nxt;

	assign ge      = (rem_q >= divisor_sh);
	assign rem_nxt = ge ? (rem_q - divisor_sh) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_W'(QUO_W)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != DIV_CNT_W'(QUO_W))) begin
			// After a subtract the remainder is below the divisor, so the top bit is free.
			rem_q <= {rem_nxt[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ rtl/led_activity_pulse_fader_core.sv @@
// Top level of the LED activity pulse fader: event decode, sequencer and output stage.
// A non-tick beat, or a tick while paused or held, is handled in idle as it is taken. A
// painting tick runs calc, scale and emit in the solid and off windows; in the pulse window
// it adds the envelope multiply and divides; the fade window adds the amplitude multiply.
// Throughput: one beat at a time; the next beat is taken once the sequencer is back in idle.
// Reset: arst_n clears all control state at once; tick length returns to 50 ms.
`default_nettype none
module led_activity_pulse_fader_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      tick_len_we,
	input  wire logic [lapf_pkg::TL_W-1:0] tick_len_wdata,
	lapf_cmd_if.sink                       cmd,
	lapf_led_if.source                     led
);
	import lapf_pkg::*;

	// Sequencer states. Each compute state launches its unit on entry, with start_q set.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CALC   = 3'd1;
	localparam logic [2:0] S_ENVMUL = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_AMPMUL = 3'd4;
	localparam logic [2:0] S_SCALE  = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	// Which window the elapsed time falls in.
	localparam logic [1:0] R_SOLID = 2'd0;
	localparam logic [1:0] R_PULSE = 2'd1;
	localparam logic [1:0] R_FADE  = 2'd2;
	localparam logic [1:0] R_OFF   = 2'd3;

	logic [2:0]           state_q;
	logic                 start_q;
	logic [1:0]           region_q;
	logic [TL_W-1:0]      tick_len_q;
	logic [COLOUR_W-1:0]  colour_q;
	logic                 paused_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [COLOUR_W-1:0]  last_q;
	logic [AMP_W-1:0]     env_q;
	logic [AMP_W-1:0]     fade_q;
	logic [AMP_W-1:0]     amp_q;
	logic                 out_valid_q;
	logic [CH_W-1:0]      out_r_q;
	logic [CH_W-1:0]      out_g_q;
	logic [CH_W-1:0]      out_b_q;

	logic                 cmd_fire;
	logic [ELAPSED_W:0]   el_sum;
	logic [ELAPSED_W-1:0] el_next;
	logic [PHASE_W:0]     ph_sum;
	logic [PHASE_W-1:0]   ph_next;
	logic [UP_W-1:0]      up;
	logic [ELAPSED_W-1:0] into;
	logic [AMPX_W-1:0]    env_sum;
	logic [AMP_W-1:0]     fade_val;
	logic [COLOUR_W-1:0]  painted;
	logic                 out_load;

	logic [MUL_W-1:0]     mul_a [NUM_LANES];
	logic [MUL_W-1:0]     mul_b [NUM_LANES];
	logic [PROD_W-1:0]    mul_p [NUM_LANES];
	logic [NUM_LANES-1:0] mul_start;
	logic [NUM_LANES-1:0] mul_busy;

	logic                 div_start;
	logic                 env_div_busy;
	logic                 fade_div_busy;
	logic [QUO_W-1:0]     env_quo;
	logic [QUO_W-1:0]     fade_drop;

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	// Time advance for a tick: elapsed saturates at the end of the fade, and the phase
	// wraps with one compare and subtract since phase plus tick stays below two periods.
	assign el_sum  = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(tick_len_q);
	assign el_next = (el_sum > (ELAPSED_W + 1)'(FADE_STOP)) ? ELAPSED_W'(FADE_STOP)
		: el_sum[ELAPSED_W-1:0];
	assign ph_sum  = {1'b0, phase_q} + (PHASE_W + 1)'(tick_len_q);
	assign ph_next = (ph_sum >= (PHASE_W + 1)'(PULSE_PERIOD))
		? PHASE_W'(ph_sum - (PHASE_W + 1)'(PULSE_PERIOD)) : ph_sum[PHASE_W-1:0];

	// Triangle position: rising for the first half period, falling for the second.
	assign up = (phase_q < PHASE_W'(HALF_PERIOD)) ? UP_W'(phase_q)
		: UP_W'(PHASE_W'(PULSE_PERIOD) - phase_q);

	// Time into the fade window; only meaningful while in that window.
	assign into = elapsed_q - ELAPSED_W'(PULSE_STOP);

	assign env_sum  = AMPX_W'(ENV_FLOOR) + AMPX_W'(env_quo);
	assign fade_val = AMP_W'(Q_ONE) - AMP_W'(fade_drop);

	// Lane 0 is shared: envelope numerator, then envelope times fade, then red.
	always_comb begin
		unique case (state_q)
			S_ENVMUL: begin
				mul_a[0] = MUL_W'(ENV_SPAN);
				mul_b[0] = MUL_W'(up);
			end
			S_AMPMUL: begin
				mul_a[0] = MUL_W'(env_q);
				mul_b[0] = MUL_W'(fade_q);
			end
			default: begin
				mul_a[0] = MUL_W'(amp_q);
				mul_b[0] = MUL_W'(colour_q[3*CH_W-1:2*CH_W]);
			end
		endcase
		mul_a[1] = MUL_W'(amp_q);
		mul_b[1] = MUL_W'(colour_q[2*CH_W-1:CH_W]);
		mul_a[2] = MUL_W'(amp_q);
		mul_b[2] = MUL_W'(colour_q[CH_W-1:0]);
	end

	assign mul_start[0] = start_q && ((state_q == S_ENVMUL) || (state_q == S_AMPMUL)
		|| (state_q == S_SCALE));
	assign mul_start[1] = start_q && (state_q == S_SCALE);
	assign mul_start[2] = start_q && (state_q == S_SCALE);
	assign div_start    = start_q && (state_q == S_DIV);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		lapf_smul u_mul (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (mul_start[i]),
			.a       (mul_a[i]),
			.b       (mul_b[i]),
			.busy    (mul_busy[i]),
			.product (mul_p[i])
		);
	end

	// Envelope: (span * up) / half-period, the numerator coming straight from lane 0.
	lapf_cdiv u_env_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend   (DIV_W'(mul_p[0])),
		.divisor_sh (ENV_DIV_SH),
		.busy       (env_div_busy),
		.quotient   (env_quo)
	);

	// Fade drop: (into << 16) / fade span. It runs alongside the envelope divide.
	lapf_cdiv u_fade_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend   (DIV_W'({into, {Q_FRAC{1'b0}}})),
		.divisor_sh (FADE_DIV_SH),
		.busy       (fade_div_busy),
		.quotient   (fade_drop)
	);

	assign painted = {mul_p[0][Q_FRAC+CH_W-1:Q_FRAC], mul_p[1][Q_FRAC+CH_W-1:Q_FRAC],
		mul_p[2][Q_FRAC+CH_W-1:Q_FRAC]};

	// A new colour goes out only when it differs from the last one sent and the
	// output register is free or being emptied in this cycle.
	assign out_load = (state_q == S_EMIT) && (painted != last_q)
		&& (!out_valid_q || led.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_len_q <= TL_W'(50);
		end else if (tick_len_we) begin
			tick_len_q <= tick_len_wdata;
		end
	end

	// Sequencer and the block's event state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			start_q   <= 1'b0;
			region_q  <= R_SOLID;
			colour_q  <= '0;
			paused_q  <= 1'b0;
			elapsed_q <= '0;
			phase_q   <= '0;
			amp_q     <= '0;
			env_q     <= '0;
			fade_q    <= '0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						unique case (cmd.kind)
							KIND_TICK: begin
								elapsed_q <= el_next;
								phase_q   <= ph_next;
								if (!paused_q && !cmd.shutdown_hold) begin
									state_q <= S_CALC;
								end
							end
							KIND_ACTIVITY: begin
								elapsed_q <= '0;
							end
							KIND_ACT_COLOUR: begin
								colour_q  <= {cmd.red_in, cmd.green_in, cmd.blue_in};
								elapsed_q <= '0;
							end
							KIND_SET_COLOUR: begin
								colour_q <= {cmd.red_in, cmd.green_in, cmd.blue_in};
							end
							KIND_PAUSE: begin
								paused_q <= 1'b1;
							end
							KIND_RESUME: begin
								paused_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_CALC: begin
					start_q <= 1'b1;
					if (elapsed_q < ELAPSED_W'(PREVIEW_LEN)) begin
						region_q <= R_SOLID;
						amp_q    <= AMP_W'(Q_ONE);
						state_q  <= S_SCALE;
					end else if (elapsed_q < ELAPSED_W'(PULSE_STOP)) begin
						region_q <= R_PULSE;
						state_q  <= S_ENVMUL;
					end else if (elapsed_q < ELAPSED_W'(FADE_STOP)) begin
						region_q <= R_FADE;
						state_q  <= S_ENVMUL;
					end else begin
						region_q <= R_OFF;
						amp_q    <= '0;
						state_q  <= S_SCALE;
					end
				end
				S_ENVMUL: begin
					if (!start_q && !mul_busy[0]) begin
						start_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!start_q && !env_div_busy) begin
						env_q   <= AMP_W'(env_sum);
						fade_q  <= fade_val;
						start_q <= 1'b1;
						if (region_q == R_FADE) begin
							state_q <= S_AMPMUL;
						end else begin
							amp_q   <= clamp_amp(env_sum);
							state_q <= S_SCALE;
						end
					end
				end
				S_AMPMUL: begin
					if (!start_q && !mul_busy[0]) begin
						amp_q   <= clamp_amp(mul_p[0][PROD_W-1:Q_FRAC]);
						start_q <= 1'b1;
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					// The lanes finish at different times, so wait for all of them.
					if (!start_q && (mul_busy == '0)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if ((painted == last_q) || out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register; the last painted colour starts as all ones so a first paint of any other colour goes out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= '1;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			last_q      <= painted;
		end else if (led.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_r_q <= painted[3*CH_W-1:2*CH_W];
			out_g_q <= painted[2*CH_W-1:CH_W];
			out_b_q <= painted[CH_W-1:0];
		end
	end

	assign led.valid     = out_valid_q;
	assign led.red_out   = out_r_q;
	assign led.green_out = out_g_q;
	assign led.blue_out  = out_b_q;

`ifndef SYNTHESIS
	// Both dividers are launched together and take the same number of steps.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		env_div_busy == fade_div_busy)
		else $error("dividers out of step");

	// No arithmetic unit may still be running when a new beat can be taken.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> ((mul_busy == '0) && !env_div_busy))
		else $error("unit busy while idle");

	// The remembered colour always matches what was last put on the output.
	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (last_q == {led.red_out, led.green_out, led.blue_out}))
		else $error("last painted colour mismatch");

	// The pulse phase stays within one period.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PHASE_W'(PULSE_PERIOD))
		else $error("pulse phase out of range");
`endif

endmodule
`default_nettype wire

@@ tb/sv/led_activity_pulse_fader_core_tb.sv @@
// Self-checking testbench for the LED activity pulse fader core.
module led_activity_pulse_fader_core_tb;
	import lapf_pkg::*;

	typedef longint unsigned u64_t;

	// The two kind codes the block is expected to ignore.
	localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

	// A painting tick in the fade window takes longest, and this many quiet cycles
	// guarantee the sequencer is back in idle.
	localparam int SETTLE_CYCLES = 100;

	// Watchdog limit in simulation time units, at a clock period of 2.
	localparam int RUN_LIMIT = 2000000;

	localparam int IDLE_PCT = 27;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic              hold;
	} lapf_event_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} led_level_t;

	logic            clk;
	logic            arst_n;
	logic            tick_len_we;
	logic [TL_W-1:0] tick_len_wdata;

	lapf_cmd_if cmd_ch ();
	lapf_led_if led_ch ();

	led_activity_pulse_fader_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_len_we    (tick_len_we),
		.tick_len_wdata (tick_len_wdata),
		.cmd            (cmd_ch),
		.led            (led_ch)
	);

	// Event beats waiting to be offered, and LED levels the block still owes us.
	lapf_event_t event_backlog[$];
	led_level_t  led_expected[$];

	// Our own copy of the fader state, updated as each event beat is accepted.
	logic [COLOUR_W-1:0] mode_rgb;
	bit                  is_paused;
	int unsigned         since_activity_ms;
	int unsigned         pulse_ms;
	logic [COLOUR_W-1:0] last_rgb;
	int unsigned         tick_ms;

	// When set, neither side inserts idle cycles.
	bit steady;

	int errors;
	int beats_taken;
	int levels_seen;
	int settings_run;

	// Free-running clock. All block inputs start at known values at time zero.
	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		tick_len_we    = 1'b0;
		tick_len_wdata = '0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.kind    = KIND_TICK;
		cmd_ch.red_in  = '0;
		cmd_ch.green_in = '0;
		cmd_ch.blue_in = '0;
		cmd_ch.shutdown_hold = 1'b0;
		led_ch.ready   = 1'b0;
		forever #1 clk = ~clk;
	end

	// Decide whether a side sits out this cycle.
	function automatic bit lull();
		return !steady && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// Triangle envelope in Q16: rises from the floor at phase zero to full scale
	// at half the period, then falls back.
	function automatic u64_t tri_level_q(input int unsigned ph);
		u64_t up;
		up = (ph < HALF_PERIOD) ? u64_t'(ph) : u64_t'(PULSE_PERIOD) - u64_t'(ph);
		return u64_t'(ENV_FLOOR) + (u64_t'(ENV_SPAN) * up) / u64_t'(HALF_PERIOD);
	endfunction

	function automatic logic [CH_W-1:0] dim_channel(input logic [CH_W-1:0] c,
		input u64_t amp);
		return CH_W'((u64_t'(c) * amp) >> Q_FRAC);
	endfunction

	// Apply one accepted event beat to our copy of the state and queue the LED
	// level it should produce, if any.
	task automatic predict_led(input lapf_event_t ev);
		u64_t        amp;
		u64_t        into;
		u64_t        drop;
		u64_t        fade;
		led_level_t  lvl;
		case (ev.kind)
			KIND_ACTIVITY: begin
				since_activity_ms = 0;
			end
			KIND_ACT_COLOUR: begin
				mode_rgb = {ev.red, ev.green, ev.blue};
				since_activity_ms = 0;
			end
			KIND_SET_COLOUR: begin
				mode_rgb = {ev.red, ev.green, ev.blue};
			end
			KIND_PAUSE: begin
				is_paused = 1'b1;
			end
			KIND_RESUME: begin
				is_paused = 1'b0;
			end
			KIND_TICK: begin
				// Time moves even when nothing is painted, and the paint below
				// sees the advanced counters.
				since_activity_ms += tick_ms;
				if (since_activity_ms > FADE_STOP) begin
					since_activity_ms = FADE_STOP;
				end
				pulse_ms = (pulse_ms + tick_ms) % PULSE_PERIOD;
				if (!is_paused && !ev.hold) begin
					if (since_activity_ms < PREVIEW_LEN) begin
						amp = u64_t'(Q_ONE);
					end else if (since_activity_ms < PULSE_STOP) begin
						amp = tri_level_q(pulse_ms);
					end else if (since_activity_ms < FADE_STOP) begin
						into = u64_t'(since_activity_ms - PULSE_STOP);
						drop = (into * u64_t'(Q_ONE)) / u64_t'(FADE_SPAN);
						fade = (drop >= u64_t'(Q_ONE)) ? 0 : u64_t'(Q_ONE) - drop;
						amp  = (tri_level_q(pulse_ms) * fade) >> Q_FRAC;
					end else begin
						amp = 0;
					end
					if (amp > u64_t'(Q_ONE)) begin
						amp = u64_t'(Q_ONE);
					end
					lvl.red   = dim_channel(mode_rgb[23:16], amp);
					lvl.green = dim_channel(mode_rgb[15:8], amp);
					lvl.blue  = dim_channel(mode_rgb[7:0], amp);
					// Only a change of colour goes out to the LED.
					if (lvl != last_rgb) begin
						last_rgb = lvl;
						led_expected.push_back(lvl);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// Driver: offers the oldest pending event beat, holds it while the block
	// stalls, and runs the prediction at the edge where the beat is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_led(event_backlog.pop_front());
				beats_taken++;
			end
			if (cmd_ch.valid && !cmd_ch.ready) begin
				// The offered beat must stay put until the block takes it.
			end else if (event_backlog.size() != 0 && !lull()) begin
				cmd_ch.valid         <= 1'b1;
				cmd_ch.kind          <= event_backlog[0].kind;
				cmd_ch.red_in        <= event_backlog[0].red;
				cmd_ch.green_in      <= event_backlog[0].green;
				cmd_ch.blue_in       <= event_backlog[0].blue;
				cmd_ch.shutdown_hold <= event_backlog[0].hold;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: checks every LED beat against the oldest expected level and
	// throttles ready at random.
	always @(posedge clk) begin
		led_level_t want;
		if (arst_n) begin
			if (led_ch.valid && led_ch.ready) begin
				levels_seen++;
				if (led_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected LED beat %h/%h/%h",
						led_ch.red_out, led_ch.green_out, led_ch.blue_out));
				end else begin
					want = led_expected.pop_front();
					if (led_ch.red_out !== want.red) begin
						report_mismatch($sformatf("red %h, expected %h",
							led_ch.red_out, want.red));
					end
					if (led_ch.green_out !== want.green) begin
						report_mismatch($sformatf("green %h, expected %h",
							led_ch.green_out, want.green));
					end
					if (led_ch.blue_out !== want.blue) begin
						report_mismatch($sformatf("blue %h, expected %h",
							led_ch.blue_out, want.blue));
					end
				end
			end
			led_ch.ready <= !lull();
		end
	end

	task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b, input logic hold);
		lapf_event_t ev;
		ev.kind  = kind;
		ev.red   = r;
		ev.green = g;
		ev.blue  = b;
		ev.hold  = hold;
		event_backlog.push_back(ev);
	endtask

	// Colour levels lean toward the extremes now and then.
	function automatic logic [CH_W-1:0] random_level();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return '0;
		end else if (roll == 1) begin
			return '1;
		end
		return CH_W'($urandom_range(0, 255));
	endfunction

	// Mostly ticks, so the elapsed time actually walks through the solid,
	// pulse, fade and off windows, with activity marks at a rate given in
	// events per thousand and the other events sprinkled in. Ignored kinds
	// are added as noise but do not count.
	task automatic queue_random(input int count, input int act_permille);
		int          made;
		int          roll;
		lapf_event_t ev;
		made = 0;
		while (made < count) begin
			roll     = $urandom_range(0, 999);
			ev.red   = random_level();
			ev.green = random_level();
			ev.blue  = random_level();
			ev.hold  = ($urandom_range(0, 99) < 15);
			if (roll < act_permille) begin
				ev.kind = $urandom_range(0, 1) ? KIND_ACTIVITY : KIND_ACT_COLOUR;
			end else if (roll < act_permille + 30) begin
				ev.kind = KIND_SET_COLOUR;
			end else if (roll < act_permille + 60) begin
				ev.kind = KIND_PAUSE;
			end else if (roll < act_permille + 100) begin
				ev.kind = KIND_RESUME;
			end else if (roll < act_permille + 115) begin
				ev.kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
			end else begin
				ev.kind = KIND_TICK;
			end
			event_backlog.push_back(ev);
			if (ev.kind != KIND_SPARE_6 && ev.kind != KIND_SPARE_7) begin
				made++;
			end
		end
	endtask

	// Wait until every queued beat has been taken and every expected level has
	// come out, then let the sequencer finish any work still in flight. Sampling on
	// the falling edge keeps clear of the driver and monitor updates.
	task automatic wait_quiet();
		while (event_backlog.size() != 0 || led_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write while the block is idle; our copy follows at once.
	task automatic set_tick_length(input int unsigned ms);
		@(posedge clk);
		tick_len_we    <= 1'b1;
		tick_len_wdata <= TL_W'(ms);
		@(posedge clk);
		tick_len_we    <= 1'b0;
		tick_ms = ms & 10'h3FF;
		settings_run++;
		@(negedge clk);
	endtask

	// Stimulus: a directed burst at the reset tick length, then a series of
	// random phases, each under its own tick length.
	initial begin
		int unsigned tick_plan[9];
		int          phase_len;
		mode_rgb          = '0;
		is_paused         = 1'b0;
		since_activity_ms = 0;
		pulse_ms          = 0;
		last_rgb          = '1;
		tick_ms           = 50;
		steady            = 1'b0;
		errors            = 0;
		beats_taken       = 0;
		levels_seen       = 0;
		settings_run      = 1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The first tick paints black over the all-ones reset value, the second
		// changes nothing. Then full white, a colour change with activity, pause
		// and hold suppression, ignored kinds and a resume while running.
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_TICK,       8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_event(KIND_SET_COLOUR, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_ACT_COLOUR, 8'hFF, 8'h00, 8'h80, 1'b1);
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_PAUSE,      8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_SET_COLOUR, 8'h01, 8'hFE, 8'h7F, 1'b0);
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_PAUSE,      8'h00, 8'h00, 8'h00, 1'b1);
		queue_event(KIND_RESUME,     8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b1);
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_SPARE_6,    8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_event(KIND_SPARE_7,    8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_event(KIND_TICK,       8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_event(KIND_RESUME,     8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_ACTIVITY,   8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_event(KIND_SET_COLOUR, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b0);
		queue_event(KIND_ACT_COLOUR, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_event(KIND_TICK,       8'h00, 8'h00, 8'h00, 1'b0);
		wait_quiet();

		// The longest and shortest legal tick lengths, the zero length that
		// freezes time, the all-ones register value, a few random lengths, and
		// the reset length again for a long walk through the pulse and fade.
		tick_plan[0] = 1000;
		tick_plan[1] = 1;
		tick_plan[2] = 0;
		tick_plan[3] = 1023;
		tick_plan[4] = $urandom_range(2, 999);
		tick_plan[5] = $urandom_range(2, 999);
		tick_plan[6] = $urandom_range(200, 1000);
		tick_plan[7] = 50;
		tick_plan[8] = $urandom_range(1, 1000);

		foreach (tick_plan[p]) begin
			set_tick_length(tick_plan[p]);
			// One phase runs with both sides always ready.
			steady = (p == 4);
			phase_len = (p == 7) ? 600 : 160;
			queue_random(phase_len, (p == 7) ? 1 : 30);
			wait_quiet();
		end
		steady = 1'b0;

		$display("Run covered %0d event beats and %0d LED beats under %0d tick lengths.",
			beats_taken, levels_seen, settings_run);
		$display("Windows exercised: solid, pulse, fade and off, with pause and hold.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#RUN_LIMIT;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
